FILE: design/cmr_pkg.sv
// cmr_pkg: shared types and constants for the CAN multi-frame reassembler.
// Used by every module under design/; depends on nothing.
package cmr_pkg;

	localparam int ID_W        = 29;
	localparam int ADDR_W      = 24;
	localparam int BYTES_W     = 64;
	localparam int S_TDATA_W   = 96;
	localparam int SEQ_W       = 9;
	localparam int TOTAL_W     = 8;
	localparam int LEN_W       = 16;
	localparam int LANES       = 7;
	localparam int START_LANES = 4;
	localparam int CNT_W       = 3;
	localparam int MIN_FRAMES  = 2;
	localparam int MIN_LENGTH  = 9;
	localparam int QUEUE_DEPTH_DEF = 2;

	// one frame's worth of bytes to emit, lane 0 first
	typedef struct packed {
		logic [LANES-1:0][7:0] lanes;
		logic [CNT_W-1:0]      cnt;
		logic                  done;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: design/cmr_front.sv
// cmr_front: address filter, sequence tracking and length bookkeeping.
// Turns each accepted frame into at most one request for cmr_back. Uses cmr_pkg.
module cmr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [cmr_pkg::ADDR_W-1:0]     cfg_data,
	input  logic                           acc,
	input  logic [cmr_pkg::ID_W-1:0]       frame_id,
	input  logic [cmr_pkg::BYTES_W-1:0]    frame_bytes,
	output logic                           push,
	output cmr_pkg::cmd_t                  cmd
);
	import cmr_pkg::*;

	logic [ADDR_W-1:0]  own_addr_q;
	logic [SEQ_W-1:0]   exp_q;
	logic [TOTAL_W-1:0] total_q;
	logic [LEN_W-1:0]   br_q;
	logic [LEN_W-1:0]   len_q;

	logic [7:0]         seq;
	logic [7:0]         b1;
	logic [LEN_W-1:0]   len_new;
	logic               hit;
	logic               is_start;
	logic               is_cont;
	logic               tot_ok;
	logic               len_ok;
	logic [SEQ_W-1:0]   want;
	logic               cont_ok;
	logic [LANES-1:0]   reach;
	logic               found;
	logic [CNT_W-1:0]   first;

	assign seq     = frame_bytes[7:0];
	assign b1      = frame_bytes[15:8];
	assign len_new = frame_bytes[31:16];
	assign hit     = frame_id[ADDR_W-1:0] == own_addr_q;
	assign is_start = hit && seq == 8'd1;
	assign is_cont  = hit && seq > 8'd1;
	assign tot_ok  = b1 >= TOTAL_W'(MIN_FRAMES);
	assign len_ok  = len_new >= LEN_W'(MIN_LENGTH);
	assign want    = exp_q + SEQ_W'(1);
	assign cont_ok = ({1'b0, seq} == want) && (want <= {1'b0, total_q});

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			reach[k] = (br_q + LEN_W'(k + 1)) >= len_q;
		end
	end

	// first lane that completes the message
	always_comb begin
		found = 1'b0;
		first = '0;
		for (int k = LANES; k >= 1; k--) begin
			if (reach[k-1]) begin
				found = 1'b1;
				first = CNT_W'(k);
			end
		end
	end

	always_comb begin
		push = 1'b0;
		cmd  = '0;
		if (acc && is_start && tot_ok && len_ok) begin
			push      = 1'b1;
			cmd.lanes = (LANES*8)'(frame_bytes[63:32]);
			cmd.cnt   = CNT_W'(START_LANES);
		end else if (acc && is_cont && cont_ok) begin
			push      = 1'b1;
			cmd.lanes = frame_bytes[63:8];
			cmd.cnt   = found ? first : CNT_W'(LANES);
			cmd.done  = found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= '0;
			exp_q      <= '0;
			total_q    <= '0;
			br_q       <= '0;
			len_q      <= '0;
		end else begin
			if (cfg_valid) begin
				own_addr_q <= cfg_data;
			end
			if (acc && is_start) begin
				total_q <= b1;
				if (tot_ok) begin
					len_q <= len_new;
					if (len_ok) begin
						exp_q <= SEQ_W'(1);
						br_q  <= LEN_W'(START_LANES);
					end
				end
			end else if (acc && is_cont) begin
				if (cont_ok && found) begin
					exp_q   <= '0;
					total_q <= '0;
					br_q    <= '0;
					len_q   <= '0;
				end else begin
					exp_q <= want;
					if (cont_ok) begin
						br_q <= br_q + LEN_W'(LANES);
					end
				end
			end
		end
	end

endmodule

FILE: design/cmr_queue.sv
// cmr_queue: small request FIFO between cmr_front and cmr_back.
// Register array with wrap pointers. Uses cmr_pkg.
module cmr_queue #(
	parameter int DEPTH = cmr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cmr_pkg::cmd_t     wr_cmd,
	input  logic              pop,
	output cmr_pkg::cmd_t     head,
	output cmr_pkg::q_stat_t  stat
);
	import cmr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = cnt_q == CW'(DEPTH);
	assign stat.empty = cnt_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

FILE: design/cmr_back.sv
// cmr_back: serializes queued requests into one payload byte per transfer.
// Output register decouples the master side. Uses cmr_pkg.
module cmr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cmr_pkg::cmd_t     head,
	input  cmr_pkg::q_stat_t  stat,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast
);
	import cmr_pkg::*;

	logic [CNT_W-1:0] idx_q;
	logic             m_tvalid_q;
	logic [7:0]       m_tdata_q;
	logic             m_tlast_q;
	logic             load;
	logic             last;

	assign load = !stat.empty && (!m_tvalid_q || m_tready);
	assign last = idx_q == head.cnt - CNT_W'(1);
	assign pop  = load && last;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= head.lanes[idx_q];
			m_tlast_q <= last && head.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
				idx_q      <= last ? '0 : idx_q + CNT_W'(1);
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/can_multiframe_reassembler_top.sv
// can_multiframe_reassembler_top: CAN multi-frame message reassembler.
// Instantiates cmr_front, cmr_queue and cmr_back; uses cmr_pkg.
//
//   channel  signals                    dir  contents
//   s_       tvalid tready tdata[95:0]  in   frame_id[28:0], frame_bytes[92:29]
//   m_       tvalid tready tdata[7:0]   out  payload_byte; tlast = message_done
//              tlast
//   cfg_     valid ready data[23:0]     in   own_address
//
// A frame is accepted whenever the request queue has room.
// The back end emits one byte per cycle while m_tready is high, so a frame costs
// one output transfer per payload byte it carries (none when dropped, 4 for a
// start frame, up to 7 for a continuation); the single byte-serializing output register sets this.
// Reset clears all message state and the queue; no clearing pass.
// Stalls on m_ only fill the queue; s_tready drops when it is full.
module can_multiframe_reassembler_top #(
	parameter int QUEUE_DEPTH = cmr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cmr_pkg::S_TDATA_W-1:0]   s_tdata,   // frame_id, frame_bytes
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // payload_byte
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cmr_pkg::ADDR_W-1:0]      cfg_data
);
	import cmr_pkg::*;

	logic    acc;
	logic    push;
	logic    pop;
	cmd_t    cmd;
	cmd_t    head;
	q_stat_t stat;

	assign cfg_ready = 1'b1;
	assign s_tready  = !stat.full;
	assign acc       = s_tvalid && s_tready;

	cmr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.acc        (acc),
		.frame_id   (s_tdata[ID_W-1:0]),
		.frame_bytes(s_tdata[ID_W+BYTES_W-1:ID_W]),
		.push       (push),
		.cmd        (cmd)
	);

	cmr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_cmd(cmd),
		.pop   (pop),
		.head  (head),
		.stat  (stat)
	);

	cmr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.stat    (stat),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("request pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("request popped from empty queue");

	a_nonempty_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.empty |-> head.cnt != '0)
		else $error("queued request carries no bytes");

endmodule

FILE: bench/can_multiframe_reassembler_top_tb.sv
// Self-checking testbench for can_multiframe_reassembler_top: drives CAN frames and
// address writes, predicts every payload byte and compares it with the m_ stream.
// Depends on cmr_pkg and the RTL under design/.
module can_multiframe_reassembler_top_tb;
	import cmr_pkg::*;

	localparam int          WATCHDOG_LIMIT = 5000;
	localparam int          IDLE_SETTLE    = 20;
	localparam int          END_DRAIN      = 30;
	localparam logic [7:0]  SEQ_NONE       = 8'd0;
	localparam logic [7:0]  SEQ_START      = 8'd1;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} payload_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;  // frame_id[28:0], frame_bytes[92:29], zeros
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [7:0]             m_tdata;       // payload_byte
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [ADDR_W-1:0]      cfg_data = '0;

	// model state
	logic [ADDR_W-1:0]      own_addr = '0;
	logic [SEQ_W-1:0]       next_seq = '0;
	logic [TOTAL_W-1:0]     frame_total = '0;
	logic [LEN_W-1:0]       bytes_rcvd = '0;
	logic [LEN_W-1:0]       msg_len = '0;
	payload_t               payload_expect[$];

	int errors = 0;
	int frames_sent = 0;
	int burst_left = 4;
	bit steady = 1'b0;
	int rx_hold = 0;
	int rx_mode = 0;
	int rx_cycle = 0;
	int idle_cycles = 0;

	can_multiframe_reassembler_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	task automatic clear_message();
		next_seq = '0;
		frame_total = '0;
		bytes_rcvd = '0;
		msg_len = '0;
	endtask

	task automatic reassemble_frame(input logic [ID_W-1:0] id, input logic [BYTES_W-1:0] fb);
		logic [7:0]       seq;
		logic [SEQ_W-1:0] want;
		int               k;
		seq = fb[7:0];
		if (id[ADDR_W-1:0] != own_addr || seq == SEQ_NONE)
			return;
		if (seq == SEQ_START) begin
			frame_total = fb[15:8];
			if (frame_total < MIN_FRAMES)
				return;
			msg_len = fb[31:16];
			if (msg_len < MIN_LENGTH)
				return;
			next_seq = 9'd1;
			bytes_rcvd = LEN_W'(START_LANES);
			for (k = 0; k < START_LANES; k++)
				payload_expect.push_back({fb[8*(4+k) +: 8], 1'b0});
			return;
		end
		// counter moves on even when the frame is rejected
		want = next_seq + 9'd1;
		next_seq = want;
		if ({1'b0, seq} != want || next_seq > {1'b0, frame_total})
			return;
		for (k = 1; k <= LANES; k++) begin
			bytes_rcvd = bytes_rcvd + 16'd1;
			if (bytes_rcvd >= msg_len) begin
				payload_expect.push_back({fb[8*k +: 8], 1'b1});
				clear_message();
				return;
			end
			payload_expect.push_back({fb[8*k +: 8], 1'b0});
		end
	endtask

	function automatic logic [BYTES_W-1:0] start_bytes(input logic [7:0] total,
			input logic [15:0] len, input logic [31:0] pay);
		return {pay, len, total, SEQ_START};
	endfunction

	function automatic logic [BYTES_W-1:0] cont_bytes(input logic [7:0] seq,
			input logic [55:0] data);
		return {data, seq};
	endfunction

	function automatic logic [ID_W-1:0] good_id();
		return {5'($urandom_range(0, 31)), own_addr};
	endfunction

	task automatic send_frame(input logic [ID_W-1:0] id, input logic [BYTES_W-1:0] fb);
		@(negedge clk);
		s_tdata <= {3'b000, fb, id};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		reassemble_frame(id, fb);
		if (id[ADDR_W-1:0] == own_addr)
			frames_sent++;
		if (!steady) begin
			burst_left--;
			if (burst_left <= 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 8);
			end
		end
	endtask

	task automatic send_noise();
		logic [ID_W-1:0]    id;
		logic [BYTES_W-1:0] fb;
		id = good_id();
		fb = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: id[ADDR_W-1:0] = own_addr ^ (24'd1 << $urandom_range(0, 23));
			1: fb[7:0] = SEQ_NONE;
			2: ;
			default: id = ID_W'($urandom);
		endcase
		send_frame(id, fb);
	endtask

	task automatic maybe_noise(input bit noisy);
		if (noisy && $urandom_range(0, 9) == 0)
			send_noise();
	endtask

	task automatic send_message(input bit noisy);
		int                 len;
		int                 conts;
		int                 total;
		int                 s;
		logic [BYTES_W-1:0] fb;
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 200)
			: $urandom_range(MIN_LENGTH, 40);
		conts = (len - START_LANES + LANES - 1) / LANES;
		total = conts + 1 + $urandom_range(0, 2);
		if ($urandom_range(0, 7) == 0)
			total = conts;  // last frame runs past the total
		if (total > 255)
			total = 255;
		maybe_noise(noisy);
		send_frame(good_id(), start_bytes(8'(total), 16'(len), $urandom));
		for (s = 2; s <= conts + 1; s++) begin
			maybe_noise(noisy);
			if (noisy && $urandom_range(0, 24) == 0)
				continue;
			fb = {$urandom, $urandom};
			fb[7:0] = 8'(s);
			send_frame(good_id(), fb);
		end
	endtask

	task automatic wait_drained();
		while (payload_expect.size() != 0)
			@(posedge clk);
	endtask

	task automatic sender_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic change_address(input logic [ADDR_W-1:0] addr);
		sender_idle();
		wait_drained();
		repeat (IDLE_SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_data <= addr;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		own_addr = addr;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// expects own_addr == all ones
	task automatic test_directed();
		send_frame({5'h1F, 24'h000000}, start_bytes(8'd2, 16'd9, 32'hFFFFFFFF));
		send_frame({5'h00, 24'hFFFFFE}, start_bytes(8'd2, 16'd9, 32'h0));
		send_frame({5'h1F, own_addr}, 64'hFFFF_FFFF_FFFF_FF00);
		send_frame({5'h00, own_addr}, start_bytes(8'd0, 16'd9, 32'h12345678));
		send_frame({5'h1F, own_addr}, start_bytes(8'd1, 16'd20, 32'h9ABCDEF0));
		send_frame({5'h00, own_addr}, start_bytes(8'd3, 16'd8, 32'hFFFFFFFF));
		// stale total and length from the rejected start
		send_frame({5'h1F, own_addr}, cont_bytes(8'd5, 56'h01020304050607));
		send_frame({5'h00, own_addr}, cont_bytes(8'd2, 56'hFF_FFFF_FFFF_FFFF));
		send_frame({5'h1F, own_addr}, cont_bytes(8'd3, 56'h0));
		send_frame({5'h00, own_addr}, cont_bytes(8'd4, 56'h5A5A5A5A5A5A5A));
		send_frame({5'h1F, own_addr}, start_bytes(8'd255, 16'hFFFF, 32'hFFFFFFFF));
		send_frame({5'h00, own_addr}, cont_bytes(8'd2, 56'hFF_FFFF_FFFF_FFFF));
		send_frame({5'h1F, own_addr}, cont_bytes(8'd3, 56'h0));
		// restart in the middle of a message
		send_frame({5'h00, own_addr}, start_bytes(8'd2, 16'd9, 32'h0));
		send_frame({5'h1F, own_addr}, cont_bytes(8'd2, 56'h11223344556677));
		send_frame({5'h00, own_addr}, start_bytes(8'd3, 16'd11, 32'hA5A55A5A));
		send_frame({5'h1F, own_addr}, cont_bytes(8'd2, 56'h55AA55AA55AA55));
		send_frame({5'h00, own_addr}, start_bytes(8'd2, 16'd30, 32'hC3C33C3C));
		send_frame({5'h1F, own_addr}, cont_bytes(8'd2, 56'hDEADBEEFCAFE01));
		send_frame({5'h00, own_addr}, cont_bytes(8'd3, 56'h0F0F0F0F0F0F0F));
		send_frame({5'h1F, own_addr}, cont_bytes(8'd3, 56'hF0F0F0F0F0F0F0));
		send_frame({5'h00, own_addr}, start_bytes(8'd2, 16'h0100, 32'h80402010));
		send_frame({5'h1F, own_addr}, cont_bytes(8'hFF, 56'h7F7F7F7F7F7F7F));
	endtask

	task automatic test_random(input int count);
		int target;
		target = frames_sent + count;
		while (frames_sent < target)
			send_message(1'b1);
	endtask

	// receiver holds off while the sender keeps offering frames
	task automatic test_backpressure();
		steady = 1'b1;
		rx_hold = 300;
		repeat (3) send_message(1'b0);
		steady = 1'b0;
	endtask

	task automatic test_drain_pause();
		send_message(1'b0);
		sender_idle();
		wait_drained();
		repeat (2) send_message(1'b1);
	endtask

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			if (rx_cycle % 48 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (rx_cycle % 5 != 0);
			endcase
		end
		rx_cycle = rx_cycle + 1;
	end

	always @(posedge clk) begin : check_payload
		payload_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (payload_expect.size() == 0) begin
				$error("payload_byte: nothing expected, got %0h (message_done %0b)",
					m_tdata, m_tlast);
				errors++;
			end else begin
				want = payload_expect.pop_front();
				if (m_tdata !== want.data) begin
					$error("payload_byte: expected %0h, got %0h", want.data, m_tdata);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("message_done: expected %0b, got %0b", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		change_address(24'hFFFFFF);
		test_directed();
		change_address(24'($urandom_range(0, 24'hFFFFFF)));
		test_random(100);
		change_address(24'h000000);
		test_backpressure();
		test_drain_pause();
		change_address(24'($urandom_range(0, 24'hFFFFFF)));
		test_random(90);
		change_address(24'hFFFFFF);
		test_random(60);
		sender_idle();
		wait_drained();
		repeat (END_DRAIN) @(posedge clk);
		if (errors == 0 && payload_expect.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: can_multiframe_reassembler_top.f
design/cmr_pkg.sv
design/cmr_front.sv
design/cmr_queue.sv
design/cmr_back.sv
design/can_multiframe_reassembler_top.sv
bench/can_multiframe_reassembler_top_tb.sv
